// ===== hdl/ccsp_pkg.sv =====
// Shared types, constants and the speaker layout of the cube speaker panner.
`default_nettype none
package ccsp_pkg;

   localparam int SPEAKER_COUNT       = 22;
   localparam int COS_TABLE_DEPTH_DEF = 256;
   localparam int SPK_W               = 5;
   localparam int POS_W               = 16;
   localparam int GAIN_W              = 16;
   localparam int DIFF_W              = 17;
   localparam int POWER_W             = 36;

   localparam logic signed [POS_W-1:0] ONE_Q14  = 16'sd16384;
   localparam logic signed [POS_W-1:0] SIDE_Q14 = 16'sd6786;
   localparam logic signed [POS_W-1:0] ZERO_Q14 = 16'sd0;
   localparam logic [GAIN_W-1:0]       UNITY_Q15 = 16'd32768;
   localparam logic [POWER_W-1:0]      ONE_Q30   = 36'd1073741824;
   localparam logic [15:0]             POWER_TOL_RESET = 16'd64;

   // axis codes, matching the column order of the layout table
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // pan status codes
   localparam logic [1:0] STAT_SELECTED = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
   localparam logic [1:0] STAT_INVALID  = 2'd2;

   // speaker layout: x, y, z per speaker, Q14
   localparam logic signed [POS_W-1:0] SPK_ROM [SPEAKER_COUNT][3] = '{
      '{-ONE_Q14,  SIDE_Q14, ZERO_Q14}, '{ ONE_Q14,  SIDE_Q14, ZERO_Q14},
      '{ ZERO_Q14, ONE_Q14,  ZERO_Q14}, '{-ONE_Q14, -ONE_Q14,  ZERO_Q14},
      '{ ONE_Q14, -ONE_Q14,  ZERO_Q14}, '{-ONE_Q14,  ONE_Q14,  ZERO_Q14},
      '{ ONE_Q14,  ONE_Q14,  ZERO_Q14}, '{ ZERO_Q14, -ONE_Q14, ZERO_Q14},
      '{-ONE_Q14,  ZERO_Q14, ZERO_Q14}, '{ ONE_Q14,  ZERO_Q14, ZERO_Q14},
      '{-ONE_Q14,  ONE_Q14,  ONE_Q14},  '{ ONE_Q14,  ONE_Q14,  ONE_Q14},
      '{ ZERO_Q14, ONE_Q14,  ONE_Q14},  '{ ZERO_Q14, ZERO_Q14, ONE_Q14},
      '{-ONE_Q14, -ONE_Q14,  ONE_Q14},  '{ ONE_Q14, -ONE_Q14,  ONE_Q14},
      '{-ONE_Q14,  ZERO_Q14, ONE_Q14},  '{ ONE_Q14,  ZERO_Q14, ONE_Q14},
      '{ ZERO_Q14, -ONE_Q14, ONE_Q14},  '{ ZERO_Q14, ONE_Q14, -ONE_Q14},
      '{-ONE_Q14,  ONE_Q14, -ONE_Q14},  '{ ONE_Q14,  ONE_Q14, -ONE_Q14}
   };

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [SPK_W-1:0]  speaker_index;
      logic [GAIN_W-1:0] speaker_gain;
      logic [1:0]        pan_status;
      logic              last_gain;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             step;
      logic             eval;
      logic             look;
      logic             mul1;
      logic             mul2;
      logic             acc;
      logic             stat;
      logic             emit;
      logic             last;
      logic [1:0]       axis;
      logic [SPK_W-1:0] spk;
      logic [SPK_W-1:0] cand;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/ccsp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ccsp_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 18,
   parameter int QUO_W = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [QUO_W-1:0]      quo
);
   localparam int DV_W  = DEN_W + QUO_W - 1;
   localparam int CMP_W = (NUM_W > DV_W) ? NUM_W : DV_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic [CMP_W-1:0] rem_ff, rem_in;
   logic [DV_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             ge;

   // one compare and subtract per cycle
   always_comb begin
      ge      = rem_ff >= CMP_W'(dvs_ff);
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = CMP_W'(num);
         dvs_in = DV_W'(den) << (QUO_W - 1);
         quo_in = '0;
         cnt_in = CNT_W'(QUO_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - CMP_W'(dvs_ff);
         end
         quo_in = {quo_ff[QUO_W-2:0], ge};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// ===== hdl/ccsp_ctrl.sv =====
// Sequencer: walks speakers, axes and candidates and drives the datapath.
`default_nettype none
module ccsp_ctrl
   import ccsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_SEARCH = 11'b000_0000_0010,
      ST_EVAL   = 11'b000_0000_0100,
      ST_DIV    = 11'b000_0000_1000,
      ST_LOOK   = 11'b000_0001_0000,
      ST_MUL1   = 11'b000_0010_0000,
      ST_MUL2   = 11'b000_0100_0000,
      ST_ACC    = 11'b000_1000_0000,
      ST_STAT   = 11'b001_0000_0000,
      ST_EMIT   = 11'b010_0000_0000,
      ST_SPARE  = 11'b100_0000_0000
   } state_type;

   localparam logic [SPK_W-1:0] LAST_IDX = SPK_W'(SPEAKER_COUNT - 1);

   state_type        state_ff, state_in;
   logic [SPK_W-1:0] spk_ff, spk_in;
   logic [SPK_W-1:0] cand_ff, cand_in;
   logic [1:0]       axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      spk_in   = spk_ff;
      cand_in  = cand_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      cmd.spk  = spk_ff;
      cmd.cand = cand_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               spk_in   = '0;
               cand_in  = '0;
               axis_in  = AXIS_Z;
               state_in = ST_SEARCH;
            end
         end
         // scan one candidate speaker per cycle
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (cand_ff == LAST_IDX) begin
               cand_in  = '0;
               state_in = ST_EVAL;
            end else begin
               cand_in = cand_ff + 1'b1;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.need_div) begin
               state_in = ST_DIV;
            end else if (axis_ff == AXIS_X) begin
               state_in = ST_MUL1;
            end else begin
               axis_in  = axis_ff - 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            if (axis_ff == AXIS_X) begin
               state_in = ST_MUL1;
            end else begin
               axis_in  = axis_ff - 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            axis_in = AXIS_Z;
            if (spk_ff == LAST_IDX) begin
               state_in = ST_STAT;
            end else begin
               spk_in   = spk_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_STAT: begin
            cmd.stat = 1'b1;
            spk_in   = '0;
            state_in = ST_EMIT;
         end
         // one result per cycle
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = spk_ff == LAST_IDX;
            if (spk_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               spk_in = spk_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         spk_ff   <= '0;
         cand_ff  <= '0;
         axis_ff  <= AXIS_Z;
      end else begin
         state_ff <= state_in;
         spk_ff   <= spk_in;
         cand_ff  <= cand_in;
         axis_ff  <= axis_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_SEARCH)
      else $error("accepted item did not start a search");
   a_cand_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> cand_ff <= LAST_IDX)
      else $error("candidate index out of range");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && !sts.div_done |=> state_ff == ST_DIV)
      else $error("left divide wait early");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> state_ff == ST_IDLE)
      else $error("not idle after final result");
`endif

endmodule
`default_nettype wire

// ===== hdl/ccsp_dpath.sv =====
// Datapath: axis search, divide, cosine table, gain products and power check.
`default_nettype none
module ccsp_dpath
   import ccsp_pkg::*;
#(
   parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire logic        csr_valid,
   input  wire logic [15:0] csr_data,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);
   localparam int QUO_W = $clog2(COS_TABLE_DEPTH + 1);
   localparam int NUM_W = 18 + $clog2(COS_TABLE_DEPTH) + 1;
   localparam int DEN_W = 18;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30_L   = 64'd1073741824;

   // cos(idx/depth * pi/2) by truncated Taylor series, rounded to Q15
   function automatic logic [GAIN_W-1:0] cos_entry(input int unsigned idx);
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned r;
      longint          sum;
      int              k;
      theta = longint'(idx) * HALF_PI_Q30 / COS_TABLE_DEPTH;
      x2    = (theta * theta) >> 30;
      term  = ONE_Q30_L;
      sum   = longint'(ONE_Q30_L);
      for (k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         case (k)
            1:       term = term / 2;
            2:       term = term / 12;
            3:       term = term / 30;
            4:       term = term / 56;
            5:       term = term / 90;
            6:       term = term / 132;
            default: term = term / 182;
         endcase
         if ((k % 2) == 1) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum <= 0) return '0;
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) return UNITY_Q15;
      return r[GAIN_W-1:0];
   endfunction

   logic [GAIN_W-1:0] cos_rom [COS_TABLE_DEPTH+1];
   for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_cos
      assign cos_rom[gi] = cos_entry(gi);
   end

   req_type                   pos_ff;
   logic [15:0]               tol_ff;
   logic                      found_ff;
   logic signed [DIFF_W-1:0]  best_ff;
   logic [GAIN_W-1:0]         ax_gain_ff [3];
   logic [GAIN_W-1:0]         prod_ff;
   logic [GAIN_W-1:0]         g_ff;
   logic [POWER_W-1:0]        power_ff;
   logic [1:0]                status_ff;
   logic [GAIN_W-1:0]         gain_mem [SPEAKER_COUNT];
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic signed [POS_W-1:0]   pos_a;
   logic signed [DIFF_W-1:0]  v, c, av_s, ao_s;
   logic [15:0]               av, ao;
   logic [16:0]               den;
   logic                      v_nonneg, member, skip, eff_found, take, same_sign;
   logic                      need_div, div_done;
   logic [NUM_W-1:0]          num;
   logic [QUO_W-1:0]          quo;
   logic [31:0]               p1, p2;
   logic [GAIN_W-1:0]         p1_r, p2_r;
   logic [POWER_W-1:0]        upper, low_sum;

   // select the position coordinate of the current axis
   always_comb begin
      unique case (cmd.axis)
         AXIS_X:  pos_a = pos_ff.pos_x;
         AXIS_Y:  pos_a = pos_ff.pos_y;
         default: pos_a = pos_ff.pos_z;
      endcase
   end

   // nearest candidate on the far side
   always_comb begin
      v = DIFF_W'(SPK_ROM[cmd.spk][cmd.axis]) - DIFF_W'(pos_a);
      c = DIFF_W'(SPK_ROM[cmd.cand][cmd.axis]) - DIFF_W'(pos_a);
      v_nonneg = !v[DIFF_W-1];
      unique case (cmd.axis)
         AXIS_Z:  member = 1'b1;
         AXIS_Y:  member = SPK_ROM[cmd.cand][2] == SPK_ROM[cmd.spk][2];
         default: member = (SPK_ROM[cmd.cand][2] == SPK_ROM[cmd.spk][2])
                           && (SPK_ROM[cmd.cand][1] == SPK_ROM[cmd.spk][1]);
      endcase
      skip      = v_nonneg ? (c >= v) : (c <= v);
      eff_found = found_ff && (cmd.cand != '0);
      take      = member && !skip
                  && (!eff_found || (v_nonneg ? (c > best_ff) : (c < best_ff)));
   end

   // axis gain decision and divide operands
   always_comb begin
      same_sign = ((v > 0) && (best_ff > 0)) || ((v < 0) && (best_ff < 0));
      av_s = v[DIFF_W-1] ? -v : v;
      ao_s = best_ff[DIFF_W-1] ? -best_ff : best_ff;
      av   = av_s[15:0];
      ao   = ao_s[15:0];
      den  = 17'(av) + 17'(ao);
      num  = NUM_W'(av) * NUM_W'(2 * COS_TABLE_DEPTH) + NUM_W'(den);
      need_div = found_ff && !same_sign && (den != '0);
   end

   ccsp_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.eval && need_div),
      .num   (num),
      .den   ({den, 1'b0}),
      .done  (div_done),
      .quo   (quo)
   );

   assign sts.need_div = need_div;
   assign sts.div_done = div_done;

   // products with half-up rounding
   always_comb begin
      p1   = 32'(ax_gain_ff[AXIS_X]) * 32'(ax_gain_ff[AXIS_Y]);
      p1_r = GAIN_W'((p1 + 32'd16384) >> 15);
      p2   = 32'(prod_ff) * 32'(ax_gain_ff[AXIS_Z]);
      p2_r = GAIN_W'((p2 + 32'd16384) >> 15);
      upper   = ONE_Q30 + POWER_W'(tol_ff);
      low_sum = power_ff + POWER_W'(tol_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= POWER_TOL_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            tol_ff <= csr_data;
         end
         if (cmd.step) begin
            found_ff <= eff_found || take;
         end
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.load) begin
         pos_ff   <= req_data;
         power_ff <= '0;
      end
      if (cmd.step && take) begin
         best_ff <= c;
      end
      if (cmd.eval && !need_div) begin
         ax_gain_ff[cmd.axis] <= (found_ff && same_sign) ? '0 : UNITY_Q15;
      end
      if (cmd.look) begin
         ax_gain_ff[cmd.axis] <= cos_rom[quo];
      end
      if (cmd.mul1) begin
         prod_ff <= p1_r;
      end
      if (cmd.mul2) begin
         g_ff              <= (p2_r > UNITY_Q15) ? UNITY_Q15 : p2_r;
         gain_mem[cmd.spk] <= (p2_r > UNITY_Q15) ? UNITY_Q15 : p2_r;
      end
      if (cmd.acc) begin
         power_ff <= power_ff + POWER_W'(32'(g_ff) * 32'(g_ff));
      end
      if (cmd.stat) begin
         if (power_ff == '0) begin
            status_ff <= STAT_OUTSIDE;
         end else if ((power_ff > upper) || (low_sum < ONE_Q30)) begin
            status_ff <= STAT_INVALID;
         end else begin
            status_ff <= STAT_SELECTED;
         end
      end
      // registered read of the gain store
      if (cmd.emit) begin
         rsp_ff.speaker_index <= cmd.spk;
         rsp_ff.speaker_gain  <= gain_mem[cmd.spk];
         rsp_ff.pan_status    <= status_ff;
         rsp_ff.last_gain     <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/cartesian_cube_speaker_panner.sv =====
// Top level of the cube speaker panner: controller plus datapath.
//
// Usage: drive req_data (pos_x, pos_y, pos_z, Q14) and raise start; the
// transfer happens at a clock edge with start high and busy low. busy stays
// high while the item is worked on. The block then returns 22 results, one
// per cycle on consecutive cycles, in speaker order 0..21, each marked by
// rsp_valid for one cycle; last_gain flags speaker 21. The receiver cannot
// stall; every result is taken in the cycle it is shown.
// Sequence: per speaker, each of the three axes scans 22 candidates (one per
// cycle), then an evaluate step, and when a cosine is needed a divide plus a
// table read; the MUL1, MUL2 and ACC states then form and accumulate the gain.
// After the last speaker a status step sets pan_status and the results are
// sent; the candidate scan takes most of the time of an item.
// One item is worked on at a time.
// csr_data writes power_tolerance (reset 64, units of 2^-30) whenever
// csr_valid is high; csr_ready is always high. Write only while idle.
// Reset is synchronous and returns the block to idle with no result pending.
`default_nettype none
module cartesian_cube_speaker_panner
   import ccsp_pkg::*;
#(
   parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ccsp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   ccsp_dpath #(
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/ccsp_checker.sv =====
// Gain predictor and result checker for the cube speaker panner.
`timescale 1ns / 100ps
`default_nettype none
module ccsp_checker
   import ccsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_count
);

   localparam int TABLE_DEPTH = COS_TABLE_DEPTH_DEF;

   logic [15:0] tolerance;
   rsp_type     expected_gains[$];

   initial begin
      fail_count = 0;
      rsp_count  = 0;
   end

   assign pending_count = expected_gains.size();

   // quarter-wave cosine, Q15, from a truncated Taylor series in Q30
   function automatic longint unsigned cosine_q15(longint unsigned idx);
      longint unsigned theta, x2, term, r;
      longint          sum;
      theta = idx * 64'd1686629713 / TABLE_DEPTH;
      x2    = (theta * theta) >> 30;
      term  = 64'd1073741824;
      sum   = 64'sd1073741824;
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         term = term / ((2 * k - 1) * (2 * k));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum <= 0) return 0;
      r = (longint'(sum) + 16384) >> 15;
      return (r > 32768) ? 32768 : r;
   endfunction

   // nearest far-side speaker coordinate on one axis, then its gain
   function automatic longint unsigned axis_gain(bit [SPEAKER_COUNT-1:0] mask, int axis,
                                                 longint p, longint v);
      bit              found;
      longint          best, c, o;
      longint unsigned av, ao, den, idx;
      found = 0;
      best  = 0;
      for (int k = 0; k < SPEAKER_COUNT; k++) begin
         if (mask[k]) begin
            c = longint'(SPK_ROM[k][axis]) - p;
            if (!(v >= 0 ? c >= v : c <= v)) begin
               if (!found || (v >= 0 ? c > best : c < best)) begin
                  found = 1;
                  best  = c;
               end
            end
         end
      end
      if (!found) return 32768;
      o = best;
      if ((v > 0 && o > 0) || (v < 0 && o < 0)) return 0;
      av  = (v < 0) ? -v : v;
      ao  = (o < 0) ? -o : o;
      den = av + ao;
      if (den == 0) return 32768;
      idx = (2 * av * TABLE_DEPTH + den) / (2 * den);
      return cosine_q15(idx);
   endfunction

   // compute all 22 results of one position
   task automatic predict_gains(req_type pos);
      longint unsigned gains[SPEAKER_COUNT];
      longint unsigned power, dev, gz, gy, gx, g;
      longint          px, py, pz;
      bit [SPEAKER_COUNT-1:0] all_mask, plane_mask, row_mask;
      logic [1:0]      status;
      rsp_type         r;
      px = pos.pos_x;
      py = pos.pos_y;
      pz = pos.pos_z;
      power = 0;
      for (int s = 0; s < SPEAKER_COUNT; s++) begin
         all_mask = '0; plane_mask = '0; row_mask = '0;
         for (int k = 0; k < SPEAKER_COUNT; k++) begin
            all_mask[k] = 1'b1;
            if (SPK_ROM[k][AXIS_Z] == SPK_ROM[s][AXIS_Z]) begin
               plane_mask[k] = 1'b1;
               if (SPK_ROM[k][AXIS_Y] == SPK_ROM[s][AXIS_Y]) row_mask[k] = 1'b1;
            end
         end
         gz = axis_gain(all_mask, AXIS_Z, pz, longint'(SPK_ROM[s][AXIS_Z]) - pz);
         gy = axis_gain(plane_mask, AXIS_Y, py, longint'(SPK_ROM[s][AXIS_Y]) - py);
         gx = axis_gain(row_mask, AXIS_X, px, longint'(SPK_ROM[s][AXIS_X]) - px);
         g  = (gx * gy + 16384) >> 15;
         g  = (g * gz + 16384) >> 15;
         gains[s] = (g > 32768) ? 32768 : g;
         power += gains[s] * gains[s];
      end
      dev = (power > 64'd1073741824) ? power - 64'd1073741824 : 64'd1073741824 - power;
      if (power == 0) status = STAT_OUTSIDE;
      else if (dev > tolerance) status = STAT_INVALID;
      else status = STAT_SELECTED;
      for (int s = 0; s < SPEAKER_COUNT; s++) begin
         r.speaker_index = s[SPK_W-1:0];
         r.speaker_gain  = gains[s][GAIN_W-1:0];
         r.pan_status    = status;
         r.last_gain     = (s == SPEAKER_COUNT - 1);
         expected_gains  = {expected_gains, r};
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // watch transfers on all three channels
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tolerance <= POWER_TOL_RESET;
      end else begin
         if (csr_valid && csr_ready) tolerance <= csr_data;
         if (start && !busy) predict_gains(req_data);
         if (rsp_valid) begin
            rsp_count++;
            if (expected_gains.size() == 0) begin
               report_mismatch("unexpected result, speaker", rsp_data.speaker_index, -1);
            end else begin
               want = expected_gains.pop_front();
               if (rsp_data.speaker_index !== want.speaker_index)
                  report_mismatch("speaker_index", rsp_data.speaker_index,
                                  want.speaker_index);
               if (rsp_data.speaker_gain !== want.speaker_gain)
                  report_mismatch("speaker_gain", rsp_data.speaker_gain,
                                  want.speaker_gain);
               if (rsp_data.pan_status !== want.pan_status)
                  report_mismatch("pan_status", rsp_data.pan_status, want.pan_status);
               if (rsp_data.last_gain !== want.last_gain)
                  report_mismatch("last_gain", rsp_data.last_gain, want.last_gain);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the cube speaker panner.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import ccsp_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;
   int          fail_count, pending_count, rsp_count;
   int          idle_pct;
   int          item_count;

   cartesian_cube_speaker_panner u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   ccsp_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop
   initial begin
      #(12 * 2000000);
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   // send one position, idling first at the current rate
   task automatic send_pos(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start    <= 1'b1;
      req_data <= '{pos_x: x, pos_y: y, pos_z: z};
      @(posedge clock);
      while (busy) @(posedge clock);
      // hold start until busy drops, then drop it
      start <= 1'b0;
      item_count++;
      @(posedge clock);
   endtask

   // wait out every expected result, then let the block settle
   task automatic drain();
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // write the tolerance register while idle
   task automatic write_tolerance(logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random position: mostly inside the cube, some anywhere
   task automatic send_random();
      logic [15:0] p[3];
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(9))
            0: p[a] = 16'($urandom);
            1: p[a] = 16'(($urandom_range(4) - 2) * 16384);
            2: p[a] = ($urandom_range(1)) ? 16'sd6786 : -16'sd6786;
            default: p[a] = 16'($urandom_range(32768) - 16384);
         endcase
      end
      send_pos(p[0], p[1], p[2]);
   endtask

   initial begin
      logic [15:0] tol_set[4];
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      idle_pct   = 0;
      item_count = 0;
      tol_set    = '{16'd0, 16'd65535, 16'd2048, 16'd64};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, speakers, extremes, field bits, with reset tolerance
      send_pos(16'sd0, 16'sd0, 16'sd0);
      send_pos(-16'sd16384, 16'sd6786, 16'sd0);
      send_pos(16'sd16384, 16'sd16384, 16'sd16384);
      send_pos(16'sd0, 16'sd16384, -16'sd16384);
      send_pos(16'sd0, -16'sd16384, 16'sd16384);
      send_pos(16'h7fff, 16'h7fff, 16'h7fff);
      send_pos(16'h8000, 16'h8000, 16'h8000);
      send_pos(16'hffff, 16'h0001, 16'h5555);
      send_pos(16'haaaa, 16'h5555, 16'haaaa);
      send_pos(16'sd8192, -16'sd8192, 16'sd8192);
      send_pos(16'sd3393, 16'sd3393, -16'sd8192);
      send_pos(16'sd0, 16'sd0, -16'sd16384);
      send_pos(16'sd20000, 16'sd0, 16'sd0);
      send_pos(16'sd0, 16'sd6786, 16'sd4000);
      drain();

      // random phases over tolerance settings and idle rates
      for (int ph = 0; ph < 4; ph++) begin
         write_tolerance(tol_set[ph]);
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 53;
            2: idle_pct = 0;
            default: idle_pct = 34;
         endcase
         repeat (25) send_random();
         drain();
      end

      $display("Sent %0d positions over four tolerance settings, checked %0d gains.",
               item_count, rsp_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
